@@ rtl/core/dcfb_pkg.sv @@
// Shared types, frame constants and the CRC-16/MODBUS byte update for the drive command frame builder
`default_nettype none
package dcfb_pkg;

	// frame layout
	localparam int unsigned FRAME_LEN = 9;
	localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

	typedef logic [IDX_W-1:0] byte_idx_t;

	// byte positions in transmit order
	localparam byte_idx_t BYTE_START  = IDX_W'(0);
	localparam byte_idx_t BYTE_HDR    = IDX_W'(1);
	localparam byte_idx_t BYTE_LSPD   = IDX_W'(2);
	localparam byte_idx_t BYTE_LPAD   = IDX_W'(3);
	localparam byte_idx_t BYTE_RSPD   = IDX_W'(4);
	localparam byte_idx_t BYTE_RPAD   = IDX_W'(5);
	localparam byte_idx_t BYTE_DIR    = IDX_W'(6);
	localparam byte_idx_t BYTE_CRC_LO = IDX_W'(7);
	localparam byte_idx_t BYTE_CRC_HI = IDX_W'(8);

	// fixed byte values
	localparam logic [7:0] START_CODE = 8'hFF;
	localparam logic [7:0] HDR_CODE   = 8'h07;
	localparam logic [7:0] PAD_CODE   = 8'h00;

	// direction codes
	localparam logic [7:0] DIR_FORWARD  = 8'b0101_0000;
	localparam logic [7:0] DIR_BACKWARD = 8'b0000_0000;
	localparam logic [7:0] DIR_ROT_LEFT = 8'b0001_0000;
	localparam logic [7:0] DIR_ROT_RGT  = 8'b0100_0000;
	localparam logic [7:0] DIR_STOP     = 8'b0101_0000;

	// crc-16/modbus
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// variable part of one frame
	typedef struct packed {
		logic [7:0] left_speed;
		logic [7:0] right_speed;
		logic [7:0] direction;
	} frame_fields_t;

	// one byte of reflected crc, bit at a time
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] acc;
		acc = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (acc[0]) begin
				acc = (acc >> 1) ^ CRC_POLY;
			end else begin
				acc = acc >> 1;
			end
		end
		return acc;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/dcfb_decode.sv @@
// Request decode: wheel speeds and direction code from the drive flags
`default_nettype none
module dcfb_decode (
	input  wire logic                   go_forward,
	input  wire logic                   go_backward,
	input  wire logic                   turn_left,
	input  wire logic                   turn_right,
	input  wire logic [7:0]             wheel_speed,
	output dcfb_pkg::frame_fields_t     fields
);
	import dcfb_pkg::*;

	logic [7:0] half_speed;
	logic [7:0] left_speed;
	logic [7:0] right_speed;
	logic [7:0] direction;

	assign half_speed = wheel_speed >> 1;

	// wheel speeds: moving turns halve the inner wheel, rotation uses full speed
	always_comb begin
		if (go_forward || go_backward) begin
			if (turn_right) begin
				left_speed  = wheel_speed;
				right_speed = half_speed;
			end else if (turn_left) begin
				left_speed  = half_speed;
				right_speed = wheel_speed;
			end else begin
				left_speed  = wheel_speed;
				right_speed = wheel_speed;
			end
		end else if (turn_left || turn_right) begin
			left_speed  = wheel_speed;
			right_speed = wheel_speed;
		end else begin
			left_speed  = 8'h00;
			right_speed = 8'h00;
		end
	end

	// direction code by priority
	always_comb begin
		if (go_forward) begin
			direction = DIR_FORWARD;
		end else if (go_backward) begin
			direction = DIR_BACKWARD;
		end else if (turn_left) begin
			direction = DIR_ROT_LEFT;
		end else if (turn_right) begin
			direction = DIR_ROT_RGT;
		end else begin
			direction = DIR_STOP;
		end
	end

	// pack the variable frame fields
	assign fields = '{left_speed: left_speed, right_speed: right_speed, direction: direction};

endmodule
`default_nettype wire

@@ rtl/core/dcfb_serializer.sv @@
// Frame serializer: emits the nine frame bytes one per cycle while frame_stall is low, with a running crc
`default_nettype none
module dcfb_serializer (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   load_valid,
	input  wire dcfb_pkg::frame_fields_t load_fields,
	output logic                        load_take,
	output logic                        frame_valid,
	input  wire logic                   frame_stall,
	output logic [7:0]                  frame_byte,
	output logic                        frame_last
);
	import dcfb_pkg::*;

	logic          busy_q;
	byte_idx_t     idx_q;
	frame_fields_t fields_q;
	logic [15:0]   crc_q;
	logic          advance;
	logic [7:0]    cur_byte;

	// output register free to take the next byte
	assign advance   = !frame_valid || !frame_stall;
	assign load_take = advance && !busy_q && load_valid;

	// byte select for the current position
	always_comb begin
		case (idx_q)
			BYTE_START:  cur_byte = START_CODE;
			BYTE_HDR:    cur_byte = HDR_CODE;
			BYTE_LSPD:   cur_byte = fields_q.left_speed;
			BYTE_LPAD:   cur_byte = PAD_CODE;
			BYTE_RSPD:   cur_byte = fields_q.right_speed;
			BYTE_RPAD:   cur_byte = PAD_CODE;
			BYTE_DIR:    cur_byte = fields_q.direction;
			BYTE_CRC_LO: cur_byte = crc_q[7:0];
			BYTE_CRC_HI: cur_byte = crc_q[15:8];
			default:     cur_byte = PAD_CODE;
		endcase
	end

	// control: frame position and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= BYTE_START;
			frame_valid <= 1'b0;
			frame_last  <= 1'b0;
		end else if (advance) begin
			if (busy_q) begin
				frame_valid <= 1'b1;
				frame_last  <= (idx_q == BYTE_CRC_HI);
				if (idx_q == BYTE_CRC_HI) begin
					busy_q <= 1'b0;
					idx_q  <= BYTE_START;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end else if (load_valid) begin
				busy_q      <= 1'b1;
				idx_q       <= BYTE_HDR;
				frame_valid <= 1'b1;
				frame_last  <= 1'b0;
			end else begin
				frame_valid <= 1'b0;
				frame_last  <= 1'b0;
			end
		end
	end

	// payload: frame fields, running crc and output byte
	always_ff @(posedge clk) begin
		if (load_take) begin
			fields_q   <= load_fields;
			crc_q      <= CRC_INIT;
			frame_byte <= START_CODE;
		end else if (advance && busy_q) begin
			frame_byte <= cur_byte;
			if (idx_q inside {[BYTE_HDR:BYTE_DIR]}) begin
				crc_q <= crc_byte(crc_q, cur_byte);
			end
		end
	end

	// a busy frame never sits on the start position
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q != BYTE_START))
		else $error("serializer busy at start position");

	// emitting the crc high byte marks the last byte and frees the serializer
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && busy_q && idx_q == BYTE_CRC_HI) |=> (frame_valid && frame_last && !busy_q))
		else $error("frame end not marked");

	// a new frame is only loaded when idle
	assert property (@(posedge clk) disable iff (!arst_n)
		load_take |=> (busy_q && idx_q == BYTE_HDR && !frame_last))
		else $error("frame load out of order");

	// last flag only on a valid byte
	assert property (@(posedge clk) disable iff (!arst_n)
		frame_last |-> frame_valid)
		else $error("last flag without valid byte");

endmodule
`default_nettype wire

@@ rtl/core/drive_command_frame_builder.sv @@
// Top level of the drive command frame builder: request register, decode and frame serializer
// Each accepted request produces a 9-byte motor command frame (0xFF, 0x07, left speed, 0,
// right speed, 0, direction, CRC-16/MODBUS low, high) on the frame port, one byte per cycle
// while frame_stall is low, with frame_last on the ninth. One decoded request waits in a
// holding register while the previous frame is still going out; a further request is stalled
// until the serializer takes the waiting one. With the serializer idle, an accepted request
// is first registered in the holding register, then the serializer loads the start byte
// into its output register; the crc is built one byte per cycle while the output is not
// stalled, as the frame is sent.
`default_nettype none
module drive_command_frame_builder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire logic       go_forward,
	input  wire logic       go_backward,
	input  wire logic       turn_left,
	input  wire logic       turn_right,
	input  wire logic [7:0] wheel_speed,
	output logic            frame_valid,
	input  wire logic       frame_stall,
	output logic [7:0]      frame_byte,
	output logic            frame_last
);
	import dcfb_pkg::*;

	frame_fields_t dec_fields;
	frame_fields_t fields_s1;
	logic          valid_s1;
	logic          load_take;

	// decode the request flags
	dcfb_decode u_decode (
		.go_forward  (go_forward),
		.go_backward (go_backward),
		.turn_left   (turn_left),
		.turn_right  (turn_right),
		.wheel_speed (wheel_speed),
		.fields      (dec_fields)
	);

	// holding register stalls only while full and not drained
	assign req_stall = valid_s1 && !load_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			fields_s1 <= dec_fields;
		end
	end

	// byte-serial frame output
	dcfb_serializer u_serializer (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_valid  (valid_s1),
		.load_fields (fields_s1),
		.load_take   (load_take),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame_byte  (frame_byte),
		.frame_last  (frame_last)
	);

endmodule
`default_nettype wire

@@ test/tb_drive_command_frame_builder.sv @@
// Self-checking testbench for the drive command frame builder: random and directed drive requests
`timescale 1ns / 100ps
module tb_drive_command_frame_builder;
	import dcfb_pkg::*;

	localparam int WATCHDOG_CYCLES = 4000;
	localparam int HOLD_OFF_CYCLES = 90;
	localparam int DRAIN_CYCLES    = 30;
	localparam int REPORT_LIMIT    = 10;

	// one drive request, flags in priority order then speed
	typedef struct packed {
		logic       fwd;
		logic       bwd;
		logic       lft;
		logic       rgt;
		logic [7:0] speed;
	} drive_req_t;

	// one expected byte of the outgoing frame
	typedef struct {
		logic [7:0] value;
		logic       last;
		int         pos;
	} frame_beat_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       req_valid   = 1'b0;
	logic       req_stall;
	logic       go_forward  = 1'b0;
	logic       go_backward = 1'b0;
	logic       turn_left   = 1'b0;
	logic       turn_right  = 1'b0;
	logic [7:0] wheel_speed = 8'h00;
	logic       frame_valid;
	logic       frame_stall = 1'b0;
	logic [7:0] frame_byte;
	logic       frame_last;

	frame_beat_t due_bytes[$];
	int          send_idle_pct     = 0;
	int          recv_idle_pct     = 0;
	int          hold_off_requests = 0;
	int          requests_sent     = 0;
	int          bytes_checked     = 0;
	int          mismatch_count    = 0;
	int          quiet_cycles      = 0;

	drive_command_frame_builder u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.go_forward  (go_forward),
		.go_backward (go_backward),
		.turn_left   (turn_left),
		.turn_right  (turn_right),
		.wheel_speed (wheel_speed),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame_byte  (frame_byte),
		.frame_last  (frame_last)
	);

	always #2 clk = ~clk;

	// reset pulse at the start of the run
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// crc-16/modbus over the six covered bytes, one message bit at a time, lsb first
	function automatic logic [15:0] modbus_crc6(input logic [7:0] msg [6]);
		logic [15:0] acc;
		logic        fb;
		acc = CRC_INIT;
		for (int i = 0; i < 6; i++) begin
			for (int b = 0; b < 8; b++) begin
				fb  = acc[0] ^ msg[i][b];
				acc = {1'b0, acc[15:1]};
				if (fb) begin
					acc = acc ^ CRC_POLY;
				end
			end
		end
		return acc;
	endfunction

	// expected motor command frame for one request, queued in transmit order
	task automatic predict_motor_frame(input drive_req_t r);
		logic [7:0]  lspd;
		logic [7:0]  rspd;
		logic [7:0]  dir;
		logic [7:0]  half;
		logic [7:0]  covered [6];
		logic [15:0] crc;
		logic [7:0]  frame [FRAME_LEN];
		frame_beat_t beat;
		half = {1'b0, r.speed[7:1]};
		// wheel speeds: a turn while moving halves the inner wheel, right wins
		if (r.fwd || r.bwd) begin
			lspd = r.rgt ? r.speed : (r.lft ? half : r.speed);
			rspd = r.rgt ? half : r.speed;
		end else if (r.lft || r.rgt) begin
			lspd = r.speed;
			rspd = r.speed;
		end else begin
			lspd = 8'h00;
			rspd = 8'h00;
		end
		// direction code: left is checked before right when only rotating
		if (r.fwd) begin
			dir = DIR_FORWARD;
		end else if (r.bwd) begin
			dir = DIR_BACKWARD;
		end else if (r.lft) begin
			dir = DIR_ROT_LEFT;
		end else if (r.rgt) begin
			dir = DIR_ROT_RGT;
		end else begin
			dir = DIR_STOP;
		end
		covered = '{HDR_CODE, lspd, PAD_CODE, rspd, PAD_CODE, dir};
		crc = modbus_crc6(covered);
		frame[0] = START_CODE;
		for (int i = 0; i < 6; i++) begin
			frame[i + 1] = covered[i];
		end
		frame[7] = crc[7:0];
		frame[8] = crc[15:8];
		for (int k = 0; k < FRAME_LEN; k++) begin
			beat.value = frame[k];
			beat.last  = (k == FRAME_LEN - 1);
			beat.pos   = k;
			due_bytes.push_back(beat);
		end
	endtask

	task automatic note_mismatch(input string what, input int pos, input int exp_v, input int got_v);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			$display("%0t: %s at frame byte %0d: expected %02h, got %02h",
				$realtime, what, pos, exp_v, got_v);
		end
	endtask

	// offer one request, wait for it to be taken, then queue its frame
	task automatic send_request(input drive_req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid   <= 1'b1;
		go_forward  <= r.fwd;
		go_backward <= r.bwd;
		turn_left   <= r.lft;
		turn_right  <= r.rgt;
		wheel_speed <= r.speed;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
		predict_motor_frame(r);
		requests_sent++;
	endtask

	// random request with speeds biased toward the extremes
	function automatic drive_req_t random_drive_req();
		drive_req_t r;
		r.fwd = 1'($urandom_range(1));
		r.bwd = 1'($urandom_range(1));
		r.lft = 1'($urandom_range(1));
		r.rgt = 1'($urandom_range(1));
		case ($urandom_range(7))
			0: r.speed = 8'h00;
			1: r.speed = 8'hFF;
			2: r.speed = 8'h01;
			default: r.speed = 8'($urandom_range(255));
		endcase
		return r;
	endfunction

	// every flag combination at full odd speed, then speed corner cases
	task automatic test_directed_frames();
		drive_req_t extras [6];
		drive_req_t r;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 16; i++) begin
			r = {i[3:0], 8'hFF};
			send_request(r);
		end
		extras = '{
			{4'b0000, 8'h00},
			{4'b1001, 8'h01},
			{4'b0110, 8'h01},
			{4'b1010, 8'h80},
			{4'b0001, 8'h55},
			{4'b0011, 8'hAA}
		};
		foreach (extras[i]) begin
			send_request(extras[i]);
		end
	endtask

	task automatic test_random_frames(input int snd_idle, input int rcv_idle, input int count);
		send_idle_pct = snd_idle;
		recv_idle_pct = rcv_idle;
		for (int i = 0; i < count; i++) begin
			send_request(random_drive_req());
		end
	endtask

	// long output stall while requests keep coming, so the input side backs up
	task automatic test_output_hold();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_requests++;
		for (int i = 0; i < 12; i++) begin
			send_request(random_drive_req());
		end
	endtask

	// output side stall, with an occasional long hold-off
	always @(posedge clk) begin : recv_side
		int hold_left;
		int hold_served;
		if (hold_served != hold_off_requests) begin
			hold_served = hold_off_requests;
			hold_left   = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			frame_stall <= 1'b1;
			hold_left--;
		end else begin
			frame_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// compare each accepted frame byte with the oldest expected one
	always @(posedge clk) begin : check_bytes
		frame_beat_t due;
		if (arst_n && frame_valid && !frame_stall) begin
			bytes_checked++;
			if (due_bytes.size() == 0) begin
				note_mismatch("frame byte with no request pending", -1, 0, frame_byte);
			end else begin
				due = due_bytes.pop_front();
				if (frame_byte !== due.value) begin
					note_mismatch("frame_byte", due.pos, due.value, frame_byte);
				end
				if (frame_last !== due.last) begin
					note_mismatch("frame_last", due.pos, due.last, frame_last);
				end
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (frame_valid && !frame_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("watchdog: no handshake for %0d cycles, %0d bytes still due",
				quiet_cycles, due_bytes.size());
			$display("drive_command_frame_builder: mismatch");
			$finish;
		end
	end

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		test_directed_frames();
		test_random_frames(30, 77, 70);
		test_random_frames(77, 30, 70);
		test_random_frames(0, 0, 70);
		test_output_hold();
		req_valid <= 1'b0;
		// drain outstanding frames, then watch for stray bytes
		while (due_bytes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (due_bytes.size() != 0) begin
			note_mismatch("bytes never sent", due_bytes[0].pos, due_bytes.size(), 0);
		end
		$display("ran %0d drive requests (all flag mixes, speed corners, random) and checked %0d bytes",
			requests_sent, bytes_checked);
		$display("gaps on both sides, one long output hold-off; %0d mismatches", mismatch_count);
		if (mismatch_count == 0) begin
			$display("drive_command_frame_builder: match");
		end else begin
			$display("drive_command_frame_builder: mismatch");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/dcfb_pkg.sv
rtl/core/dcfb_decode.sv
rtl/core/dcfb_serializer.sv
rtl/core/drive_command_frame_builder.sv
test/tb_drive_command_frame_builder.sv
